/* hdl/ddm_pkg.sv */
`timescale 1ns / 1ps

package ddm_pkg;

  // Fixed-point format of speeds and duty values
  localparam int FRAC_BITS = 12;
  localparam int SPD_W     = 16;                         // Q3.12 speed fields
  localparam int CFG_W     = 16;                         // configuration registers
  localparam int DUTY_W    = FRAC_BITS + 1;              // 0 .. 1.0 inclusive
  localparam int PROD_W    = 2 * SPD_W;                  // |angular| * track width
  localparam int MAG_W     = PROD_W - FRAC_BITS - 1;     // wheel drive magnitude
  localparam int DRV_W     = MAG_W + 1;                  // signed wheel drive
  localparam int CNT_W     = $clog2(DUTY_W + 1);         // divider step counter

  localparam logic [MAG_W-1:0] ONE = MAG_W'(1) << FRAC_BITS;

  // Transaction kinds on the input channel
  localparam logic CMD_VELOCITY = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  // APB register map, word decode on paddr[2]
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_AXLE_SPAN  = 1'b0;
  localparam logic REG_TIMEOUT_MS = 1'b1;

  localparam logic [CFG_W-1:0] AXLE_SPAN_RST  = CFG_W'(2048);
  localparam logic [CFG_W-1:0] TIMEOUT_MS_RST = CFG_W'(500);

  typedef struct packed {
    logic [CFG_W-1:0] axle_span;
    logic [CFG_W-1:0] timeout_ms;
  } ddm_cfg_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] peak;
  } ddm_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] quot;
  } ddm_div_rsp_t;

endpackage

/* hdl/diff_drive_mixer_with_watchdog.sv */
`timescale 1ns / 1ps
// Sequence: a tick transaction goes straight to the done state; a velocity command passes
//   through multiply and mix, and one that needs scaling also takes two 13-step divider passes.
// Throughput: one transaction in flight; a new one is taken only once in_stall drops,
//   since in_stall holds until the result is registered.
// Reset (rst_n, synchronous): track width 0.5 m, timeout 500 ms, counter and wheel
//   registers cleared, no result pending.

module diff_drive_mixer_with_watchdog
  import ddm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_cmd,
  input  logic signed [SPD_W-1:0] in_linear_speed,
  input  logic signed [SPD_W-1:0] in_angular_speed,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_left_forward,
  output logic [DUTY_W-1:0]       out_left_duty,
  output logic                    out_right_forward,
  output logic [DUTY_W-1:0]       out_right_duty,
  output logic                    out_watchdog_stopped,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a transaction
  localparam logic [2:0] ST_MUL  = 3'd1;  // |angular| * track width
  localparam logic [2:0] ST_MIX  = 3'd2;  // form wheel drives, pick scaling
  localparam logic [2:0] ST_DIVL = 3'd3;  // divider works on the left wheel
  localparam logic [2:0] ST_DIVR = 3'd4;  // divider works on the right wheel
  localparam logic [2:0] ST_DONE = 3'd5;  // hand the result to the output register

  ddm_cfg_t     cfg;
  ddm_div_req_t div_req;
  ddm_div_rsp_t div_rsp;

  logic [2:0] state_r, state_nxt;

  // Latched command operands
  logic signed [SPD_W-1:0] lin_r;
  logic                    ang_neg_r;
  logic [SPD_W-1:0]        ang_mag_r;
  logic [PROD_W-1:0]       prod_r;
  logic [MAG_W-1:0]        rm_r;
  logic [MAG_W-1:0]        peak_r;

  // Architectural state
  logic [CFG_W-1:0]  elapsed_ms_r;
  logic [DUTY_W-1:0] left_duty_r;
  logic [DUTY_W-1:0] right_duty_r;
  logic              left_dir_r;
  logic              right_dir_r;

  // Output register
  logic              out_valid_r;
  logic              out_left_forward_r;
  logic [DUTY_W-1:0] out_left_duty_r;
  logic              out_right_forward_r;
  logic [DUTY_W-1:0] out_right_duty_r;
  logic              out_watchdog_stopped_r;

  logic in_accept;
  logic out_free;
  logic out_load;

  // Mixing datapath
  logic [MAG_W-1:0]        hm;
  logic signed [DRV_W-1:0] h;
  logic signed [DRV_W-1:0] lin_ext;
  logic signed [DRV_W-1:0] lv;
  logic signed [DRV_W-1:0] rv;
  logic [DRV_W-1:0]        lv_abs;
  logic [DRV_W-1:0]        rv_abs;
  logic [MAG_W-1:0]        lm;
  logic [MAG_W-1:0]        rm;
  logic [MAG_W-1:0]        peak;
  logic                    need_scale;

  // Watchdog
  logic [CFG_W-1:0] elapsed_inc;

  ddm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ddm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign out_load  = (state_r == ST_DONE) & out_free;

  // Half-track term: truncate the magnitude, then restore the sign
  assign hm      = prod_r[PROD_W-1:FRAC_BITS+1];
  assign h       = ang_neg_r ? -$signed({1'b0, hm}) : $signed({1'b0, hm});
  assign lin_ext = DRV_W'(lin_r);
  assign lv      = lin_ext - h;
  assign rv      = lin_ext + h;
  assign lv_abs  = lv[DRV_W-1] ? DRV_W'(-lv) : DRV_W'(lv);
  assign rv_abs  = rv[DRV_W-1] ? DRV_W'(-rv) : DRV_W'(rv);
  assign lm      = lv_abs[MAG_W-1:0];
  assign rm      = rv_abs[MAG_W-1:0];
  assign peak    = (lm > rm) ? lm : rm;
  assign need_scale = (peak > ONE);

  // Saturating tick count
  assign elapsed_inc = (elapsed_ms_r == {CFG_W{1'b1}}) ? elapsed_ms_r
                                                       : elapsed_ms_r + CFG_W'(1);

  // Start the divider on the left wheel from the mix stage, then on the right
  // wheel as soon as the left quotient lands.
  always_comb begin
    div_req.start = 1'b0;
    div_req.mag   = rm_r;
    div_req.peak  = peak_r;
    case (state_r)
      ST_MIX: begin
        div_req.start = need_scale;
        div_req.mag   = lm;
        div_req.peak  = peak;
      end
      ST_DIVL: begin
        div_req.start = div_rsp.done;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_cmd == CMD_TICK) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_MIX;
      ST_MIX:  state_nxt = need_scale ? ST_DIVL : ST_DONE;
      ST_DIVL: begin
        if (div_rsp.done) begin
          state_nxt = ST_DIVR;
        end
      end
      ST_DIVR: begin
        if (div_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and wheel registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      elapsed_ms_r <= '0;
      left_duty_r  <= '0;
      right_duty_r <= '0;
      left_dir_r   <= 1'b0;
      right_dir_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_cmd == CMD_TICK) begin
              // Tick: advance the watchdog and force a stop once it expires
              elapsed_ms_r <= elapsed_inc;
              if (elapsed_inc > cfg.timeout_ms) begin
                left_duty_r  <= '0;
                right_duty_r <= '0;
                left_dir_r   <= 1'b1;
                right_dir_r  <= 1'b1;
              end
            end else begin
              elapsed_ms_r <= '0;
            end
          end
        end
        ST_MIX: begin
          // Direction follows the sign before any scaling
          left_dir_r  <= ~lv[DRV_W-1];
          right_dir_r <= ~rv[DRV_W-1];
          if (!need_scale) begin
            left_duty_r  <= lm[DUTY_W-1:0];
            right_duty_r <= rm[DUTY_W-1:0];
          end
        end
        ST_DIVL: begin
          if (div_rsp.done) begin
            left_duty_r <= div_rsp.quot;
          end
        end
        ST_DIVR: begin
          if (div_rsp.done) begin
            right_duty_r <= div_rsp.quot;
          end
        end
        default: ;
      endcase
    end
  end

  // Operand registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      lin_r     <= in_linear_speed;
      ang_neg_r <= in_angular_speed[SPD_W-1];
      ang_mag_r <= in_angular_speed[SPD_W-1] ? SPD_W'(-in_angular_speed)
                                             : SPD_W'(in_angular_speed);
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(ang_mag_r) * PROD_W'(cfg.axle_span);
    end
    if (state_r == ST_MIX) begin
      rm_r   <= rm;
      peak_r <= peak;
    end
  end

  // Output register: hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_forward_r     <= left_dir_r;
      out_left_duty_r        <= left_duty_r;
      out_right_forward_r    <= right_dir_r;
      out_right_duty_r       <= right_duty_r;
      out_watchdog_stopped_r <= (elapsed_ms_r > cfg.timeout_ms);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_left_forward     = out_left_forward_r;
  assign out_left_duty        = out_left_duty_r;
  assign out_right_forward    = out_right_forward_r;
  assign out_right_duty       = out_right_duty_r;
  assign out_watchdog_stopped = out_watchdog_stopped_r;

endmodule

/* hdl/ddm_cfg.sv */
`timescale 1ns / 1ps

module ddm_cfg
  import ddm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output ddm_cfg_t          cfg
);

  logic [CFG_W-1:0] axle_span_r;
  logic [CFG_W-1:0] timeout_ms_r;
  logic             wr_en;
  logic             reg_sel;

  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axle_span_r  <= AXLE_SPAN_RST;
      timeout_ms_r <= TIMEOUT_MS_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_AXLE_SPAN:  axle_span_r  <= pwdata[CFG_W-1:0];
        REG_TIMEOUT_MS: timeout_ms_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_AXLE_SPAN:  prdata = DATA_W'(axle_span_r);
      REG_TIMEOUT_MS: prdata = DATA_W'(timeout_ms_r);
      default:        prdata = '0;
    endcase
  end

  assign cfg.axle_span  = axle_span_r;
  assign cfg.timeout_ms = timeout_ms_r;

endmodule

/* hdl/ddm_div.sv */
`timescale 1ns / 1ps

module ddm_div
  import ddm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  ddm_div_req_t req,
  output ddm_div_rsp_t rsp
);

  // Restoring division of mag * 2^FRAC_BITS by peak, one quotient bit a cycle.
  // mag <= peak, so the quotient fits DUTY_W bits and the upper dividend
  // bits (mag >> 1) already sit below peak.
  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [MAG_W-1:0]  rem_r;
  logic [MAG_W-1:0]  peak_r;
  logic [DUTY_W-1:0] lo_r;
  logic [DUTY_W-1:0] q_r;

  logic [MAG_W:0]    trial;
  logic [MAG_W:0]    diff;
  logic              ge;
  logic [MAG_W-1:0]  rem_nxt;

  assign trial   = {rem_r, lo_r[DUTY_W-1]};
  assign diff    = trial - {1'b0, peak_r};
  assign ge      = (trial >= {1'b0, peak_r});
  assign rem_nxt = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DUTY_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= {1'b0, req.mag[MAG_W-1:1]};
      lo_r   <= {req.mag[0], {FRAC_BITS{1'b0}}};
      peak_r <= req.peak;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[DUTY_W-2:0], 1'b0};
      q_r   <= {q_r[DUTY_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule
